@@ rtl/lhbp_pkg.sv @@
// Shared types and constants for the local history branch predictor.
// No dependencies; every other file of the block imports this package.
package lhbp_pkg;

  // Word field widths
  localparam int IDX_IN_W = 4;
  localparam int HIST_W   = 2;
  localparam int CTR_W    = 2;
  localparam int MISS_W   = 16;

  // Index values the input field can carry
  localparam int IDX_IN_RANGE = 1 << IDX_IN_W;

  // Default table size
  localparam int DEF_ENTRIES = 16;

  // Counter and miss count limits
  localparam int                CTRS_PER_ENTRY = 4;
  localparam logic [CTR_W-1:0]  CTR_MAX        = 2'd3;
  localparam logic [CTR_W-1:0]  CTR_MIN        = 2'd0;
  localparam logic [CTR_W-1:0]  CTR_TAKEN_MIN  = 2'd2;
  localparam logic [MISS_W-1:0] MISS_MAX       = 16'hFFFF;

  // One table entry: history, four pattern counters and the miss count
  typedef struct packed {
    logic [HIST_W-1:0]                    hist;
    logic [CTRS_PER_ENTRY-1:0][CTR_W-1:0] ctr;
    logic [MISS_W-1:0]                    miss;
  } entry_t;

  // Port requests from the update logic to the table
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } tbl_ctrl_t;

endpackage

@@ rtl/lhbp_in_if.sv @@
// Input channel of the branch predictor: branch entry and resolved outcome.
// Depends on lhbp_pkg for the field widths.
interface lhbp_in_if;
  import lhbp_pkg::*;

  logic                valid;
  logic                ready;
  logic [IDX_IN_W-1:0] entry_index;
  logic                actual_taken;

  modport source (output valid, output entry_index, output actual_taken, input ready);
  modport sink   (input valid, input entry_index, input actual_taken, output ready);
endinterface

@@ rtl/lhbp_out_if.sv @@
// Result channel of the branch predictor: prediction, miss flag and miss count.
// Depends on lhbp_pkg for the field widths.
interface lhbp_out_if;
  import lhbp_pkg::*;

  logic              valid;
  logic              ready;
  logic [HIST_W-1:0] history_before;
  logic              predicted_taken;
  logic              mispredicted;
  logic [MISS_W-1:0] miss_total;

  modport source (output valid, output history_before, output predicted_taken,
                  output mispredicted, output miss_total, input ready);
  modport sink   (input valid, input history_before, input predicted_taken,
                  input mispredicted, input miss_total, output ready);
endinterface

@@ rtl/local_history_branch_predictor.sv @@
// Top level of the two-level local history branch predictor.
// Depends on lhbp_pkg, lhbp_in_if, lhbp_out_if and lhbp_table.
//
// Usage:
//   in_chan carries one word per resolved branch: entry_index and
//   actual_taken. An index of ENTRIES or more wraps modulo ENTRIES.
//   out_chan returns one word per input word, in order: the entry's history
//   before the update, the prediction, the miss flag and the entry's
//   saturating miss count after the update.
//   Both channels move a word on a clock edge where valid and ready are high.
//   Path: a word accepted on in_chan is read from the table in the read
//   stage, then goes through the result register, which drives out_chan.
//   Throughput: one word per cycle while out_chan.ready is high. A word
//   for the same entry as the one just before it takes the updated entry
//   from a bypass around the table, so no bubble is needed.
//   Reset: rst_n is synchronous. Afterwards a clearing pass zeroes the table
//   entry by entry; in_chan.ready stays low until it ends.
//   Stall: when out_chan.ready is low the result register holds, one more
//   word may wait in the read stage, and then in_chan.ready drops.
module local_history_branch_predictor #(
  parameter int ENTRIES = lhbp_pkg::DEF_ENTRIES
) (
  input  logic              clk,
  input  logic              rst_n,
  lhbp_in_if.sink           in_chan,
  lhbp_out_if.source        out_chan
);
  import lhbp_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // Index wrap table, worked out at elaboration
  logic [IDX_W-1:0] wrap_tab [IDX_IN_RANGE];
  for (genvar g = 0; g < IDX_IN_RANGE; g++) begin : g_wrap
    assign wrap_tab[g] = IDX_W'(g % ENTRIES);
  end

  logic              init_done;
  logic              accept;
  logic              s1_adv;
  logic              s1_valid_r;
  logic [IDX_W-1:0]  s1_idx_r;
  logic              s1_taken_r;
  tbl_ctrl_t         tbl_ctrl;
  entry_t            cur_entry;
  entry_t            new_entry;
  logic [CTR_W-1:0]  cur_ctr;
  logic [CTR_W-1:0]  new_ctr;
  logic              pred;
  logic              miss;

  logic              out_valid_r;
  logic [HIST_W-1:0] out_hist_r;
  logic              out_pred_r;
  logic              out_miss_r;
  logic [MISS_W-1:0] out_total_r;

  // Handshake
  assign s1_adv        = !out_valid_r || out_chan.ready;
  assign in_chan.ready = init_done && (!s1_valid_r || s1_adv);
  assign accept        = in_chan.valid && in_chan.ready;

  assign tbl_ctrl.rd_en = accept;
  assign tbl_ctrl.wr_en = s1_valid_r && s1_adv;

  lhbp_table #(
    .ENTRIES (ENTRIES)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (tbl_ctrl),
    .rd_addr   (wrap_tab[in_chan.entry_index]),
    .wr_addr   (s1_idx_r),
    .wr_data   (new_entry),
    .rd_entry  (cur_entry),
    .init_done (init_done)
  );

  // Read stage: holds the word while its entry comes out of the table
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_idx_r   <= wrap_tab[in_chan.entry_index];
      s1_taken_r <= in_chan.actual_taken;
    end
  end

  // Predict, then move counter, history and miss count
  always_comb begin
    cur_ctr = cur_entry.ctr[cur_entry.hist];
    pred    = (cur_ctr >= CTR_TAKEN_MIN);
    miss    = (pred != s1_taken_r);

    if (s1_taken_r) begin
      new_ctr = (cur_ctr != CTR_MAX) ? cur_ctr + CTR_W'(1) : cur_ctr;
    end else begin
      new_ctr = (cur_ctr != CTR_MIN) ? cur_ctr - CTR_W'(1) : cur_ctr;
    end

    new_entry                     = cur_entry;
    new_entry.ctr[cur_entry.hist] = new_ctr;
    new_entry.hist                = {cur_entry.hist[0], s1_taken_r};
    if (miss && (cur_entry.miss != MISS_MAX)) begin
      new_entry.miss = cur_entry.miss + MISS_W'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_valid_r && s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_adv) begin
      out_hist_r  <= cur_entry.hist;
      out_pred_r  <= pred;
      out_miss_r  <= miss;
      out_total_r <= new_entry.miss;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.history_before  = out_hist_r;
  assign out_chan.predicted_taken = out_pred_r;
  assign out_chan.mispredicted    = out_miss_r;
  assign out_chan.miss_total      = out_total_r;

`ifndef ASSERT_OFF
  // Nothing enters before the clearing pass is over
  a_ready_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !init_done |-> !in_chan.ready)
    else $error("input taken during clearing pass");

  // A word in the read stage is kept while the result register is blocked
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r)
    else $error("read stage word lost under stall");

  // A miss always leaves a nonzero count
  a_miss_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_miss_r |-> out_total_r != '0)
    else $error("miss reported with zero count");
`endif

endmodule

@@ rtl/lhbp_table.sv @@
// Entry memory of the branch predictor with its clearing pass and a
// write-to-read bypass. Depends on lhbp_pkg.
module lhbp_table #(
  parameter int ENTRIES = lhbp_pkg::DEF_ENTRIES
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  lhbp_pkg::tbl_ctrl_t                    ctrl,
  input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] rd_addr,
  input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] wr_addr,
  input  lhbp_pkg::entry_t                       wr_data,
  output lhbp_pkg::entry_t                       rd_entry,
  output logic                                   init_done
);
  import lhbp_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  entry_t             mem [ENTRIES];
  entry_t             rd_data_r;
  entry_t             fwd_data_r;
  logic               fwd_r;
  logic               init_done_r;
  logic [CNT_W-1:0]   clr_cnt_r;

  // Clearing sweep after reset, one entry per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_done_r <= 1'b0;
      clr_cnt_r   <= '0;
    end else if (!init_done_r) begin
      clr_cnt_r <= clr_cnt_r + CNT_W'(1);
      if (clr_cnt_r == CNT_W'(ENTRIES - 1)) begin
        init_done_r <= 1'b1;
      end
    end
  end

  // Single write port: sweep first, then updates
  always_ff @(posedge clk) begin
    if (!init_done_r) begin
      mem[clr_cnt_r[IDX_W-1:0]] <= '0;
    end else if (ctrl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read; data holds while no new read is issued
  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rd_data_r  <= mem[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  // Bypass flag: read and write of the same entry at one edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (ctrl.rd_en) begin
      fwd_r <= ctrl.wr_en && (rd_addr == wr_addr);
    end
  end

  assign rd_entry  = fwd_r ? fwd_data_r : rd_data_r;
  assign init_done = init_done_r;

`ifndef ASSERT_OFF
  // No update may be written while the sweep still owns the port
  a_no_wr_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.wr_en |-> init_done_r)
    else $error("table update during clearing pass");

  // A same-entry read and write must select the bypass next cycle
  a_fwd_set: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.rd_en && ctrl.wr_en && (rd_addr == wr_addr) |=> fwd_r)
    else $error("bypass not taken for same-entry access");

  // No reads are issued before the sweep ends
  a_no_rd_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.rd_en |-> init_done_r)
    else $error("table read during clearing pass");
`endif

endmodule
